// ----- rtl/core/int_to_radix_ascii_unit_assert.svh -----
// Assertion macros for the radix conversion unit.
`ifndef INT_TO_RADIX_ASCII_UNIT_ASSERT_SVH
`define INT_TO_RADIX_ASCII_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define I2RA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2ra: implication check failed");
`define I2RA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2ra: next-cycle check failed");
`else
`define I2RA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define I2RA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/core/i2ra_pkg.sv -----
`default_nettype none
package i2ra_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 32;
   // quotient bits resolved per divider cycle
   localparam int STEP_BITS = 8;
   localparam int RADIX_WIDTH = 6;
   localparam int CHAR_WIDTH = 7;

   typedef logic [RADIX_WIDTH-1:0] digit_type;
   typedef logic [CHAR_WIDTH-1:0] char_type;

   localparam digit_type RADIX_RESET = 6'd10;
   localparam digit_type RADIX_MIN = 6'd2;
   localparam digit_type RADIX_MAX = 6'd36;
   localparam digit_type DECIMAL_DIGITS = 6'd10;
   localparam char_type ASCII_ZERO = 7'h30;
   localparam char_type ASCII_LETTER_A = 7'h41;
   localparam char_type ASCII_MINUS = 7'h2D;

   // clamp the programmed base into 2..36
   function automatic digit_type effective_radix(input digit_type raw);
      digit_type result;
      if (raw < RADIX_MIN) begin
         result = RADIX_MIN;
      end else if (raw > RADIX_MAX) begin
         result = RADIX_MAX;
      end else begin
         result = raw;
      end
      return result;
   endfunction

   function automatic char_type digit_char(input digit_type d);
      char_type result;
      if (d < DECIMAL_DIGITS) begin
         result = ASCII_ZERO + char_type'(d);
      end else begin
         result = ASCII_LETTER_A + char_type'(d - DECIMAL_DIGITS);
      end
      return result;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/int_to_radix_ascii_unit.sv -----
`default_nettype none
// Flow: the item is taken in idle, then each digit is divided out in the shared
// divider (8 quotient bits per cycle) and written to the digit store, then each
// digit character is read from the digit store and then shown, after a leading
// '-' for a negative value. One item at a time; req_stall stays high until the
// last character is taken.
// Reset (synchronous, active high) returns to idle with radix 10.
module int_to_radix_ascii_unit #(
   parameter int VALUE_WIDTH = i2ra_pkg::DEFAULT_VALUE_WIDTH
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire signed [VALUE_WIDTH-1:0] req_value,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output i2ra_pkg::char_type           rsp_character,
   output logic                         rsp_last,
   input  wire                          csr_write_enable,
   input  wire i2ra_pkg::digit_type     csr_write_data
);

   localparam int STEPS = (VALUE_WIDTH + i2ra_pkg::STEP_BITS - 1) / i2ra_pkg::STEP_BITS;
   localparam int PAD_W = STEPS * i2ra_pkg::STEP_BITS;
   localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int COUNT_W = $clog2(VALUE_WIDTH + 1);
   localparam int ADDR_W = $clog2(VALUE_WIDTH);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIVIDE = 5'b00010,
      ST_SIGN   = 5'b00100,
      ST_FETCH  = 5'b01000,
      ST_SHOW   = 5'b10000
   } state_type;

   state_type                 state_ff, state_in;
   i2ra_pkg::digit_type       radix_ff, radix_in;
   logic                      neg_ff, neg_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [STEP_CNT_W-1:0]     step_ff, step_in;
   logic [PAD_W-1:0]          work_ff, work_in;
   i2ra_pkg::digit_type       rem_ff, rem_in;
   i2ra_pkg::digit_type       rd_data_ff;

   i2ra_pkg::digit_type       digit_mem [VALUE_WIDTH];

   logic                      req_accept;
   logic                      rsp_accept;
   logic [VALUE_WIDTH-1:0]    magnitude;
   logic [i2ra_pkg::STEP_BITS-1:0] quo;
   i2ra_pkg::digit_type       rem_next;
   logic [PAD_W-1:0]          work_shift;
   logic                      last_step;
   logic                      dig_we;
   logic [COUNT_W-1:0]        count_dec;
   logic [ADDR_W-1:0]         rd_addr;

   i2ra_div_step u_div_step (
      .base    (i2ra_pkg::effective_radix(radix_ff)),
      .rem_in  (rem_ff),
      .chunk   (work_ff[PAD_W-1 -: i2ra_pkg::STEP_BITS]),
      .quo     (quo),
      .rem_out (rem_next)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == ST_SIGN) || (state_ff == ST_SHOW);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign rsp_last   = (state_ff == ST_SHOW) && (count_ff == COUNT_W'(1));
   assign rsp_character = (state_ff == ST_SIGN) ? i2ra_pkg::ASCII_MINUS
                                                : i2ra_pkg::digit_char(rd_data_ff);

   assign magnitude  = req_value[VALUE_WIDTH-1] ? (~req_value + 1'b1) : req_value;
   assign work_shift = (work_ff << i2ra_pkg::STEP_BITS) | PAD_W'(quo);
   assign last_step  = (step_ff == STEP_CNT_W'(STEPS - 1));
   assign dig_we     = (state_ff == ST_DIVIDE) && last_step;
   assign count_dec  = count_ff - COUNT_W'(1);
   assign rd_addr    = count_dec[ADDR_W-1:0];

   always_comb begin
      state_in = state_ff;
      radix_in = csr_write_enable ? csr_write_data : radix_ff;
      neg_in   = neg_ff;
      count_in = count_ff;
      step_in  = step_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               neg_in   = req_value[VALUE_WIDTH-1];
               work_in  = PAD_W'(magnitude);
               rem_in   = '0;
               count_in = '0;
               step_in  = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            work_in = work_shift;
            if (last_step) begin
               // digit done: rem_next is written to the store this cycle
               count_in = count_ff + COUNT_W'(1);
               step_in  = '0;
               rem_in   = '0;
               if (work_shift == '0) begin
                  state_in = neg_ff ? ST_SIGN : ST_FETCH;
               end
            end else begin
               step_in = step_ff + STEP_CNT_W'(1);
               rem_in  = rem_next;
            end
         end
         ST_SIGN: begin
            if (rsp_accept) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_accept) begin
               count_in = count_dec;
               state_in = rsp_last ? ST_IDLE : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= i2ra_pkg::RADIX_RESET;
         neg_ff   <= 1'b0;
         count_ff <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         neg_ff   <= neg_in;
         count_ff <= count_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff <= '0;
         rem_ff  <= '0;
      end else begin
         work_ff <= work_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dig_we) begin
         digit_mem[count_ff[ADDR_W-1:0]] <= rem_next;
      end
      if (state_ff == ST_FETCH) begin
         rd_data_ff <= digit_mem[rd_addr];
      end
   end

`include "int_to_radix_ascii_unit_assert.svh"

   `I2RA_ASSERT_IMPL(a_busy_while_emit, clock, reset, rsp_valid, req_stall)
   `I2RA_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_W'(VALUE_WIDTH))
   `I2RA_ASSERT_IMPL(a_show_has_digit, clock, reset, state_ff == ST_SHOW, count_ff != '0)
   `I2RA_ASSERT_NEXT(a_last_frees, clock, reset, rsp_accept && rsp_last, !req_stall)

endmodule
`default_nettype wire

// ----- rtl/core/i2ra_div_step.sv -----
`default_nettype none
// One chunk of long division by a small base: STEP_BITS restoring steps
// on a remainder that always stays below the base.
module i2ra_div_step (
   input  wire i2ra_pkg::digit_type        base,
   input  wire i2ra_pkg::digit_type        rem_in,
   input  wire [i2ra_pkg::STEP_BITS-1:0]   chunk,
   output logic [i2ra_pkg::STEP_BITS-1:0]  quo,
   output i2ra_pkg::digit_type             rem_out
);

   logic [i2ra_pkg::RADIX_WIDTH:0] trial;
   i2ra_pkg::digit_type             r;

   always_comb begin
      r = rem_in;
      quo = '0;
      trial = '0;
      for (int i = 0; i < i2ra_pkg::STEP_BITS; i++) begin
         trial = {r, chunk[i2ra_pkg::STEP_BITS-1-i]};
         if (trial >= {1'b0, base}) begin
            trial = trial - {1'b0, base};
            quo[i2ra_pkg::STEP_BITS-1-i] = 1'b1;
         end
         r = trial[i2ra_pkg::RADIX_WIDTH-1:0];
      end
      rem_out = r;
   end

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import i2ra_pkg::*;

   localparam int VW = DEFAULT_VALUE_WIDTH;
   localparam int PHASE_ITEMS = 20;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 3000;

   typedef struct packed {
      char_type character;
      logic     last;
   } text_char_t;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [VW-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   char_type             rsp_character;
   logic                 rsp_last;
   logic                 csr_write_enable = 1'b0;
   digit_type            csr_write_data = '0;

   logic signed [VW-1:0] pending_values[$];
   text_char_t           expected_chars[$];
   digit_type            radix_setting = RADIX_RESET;
   logic                 req_taken = 1'b0;
   logic                 steady_phase = 1'b0;
   logic                 hold_done = 1'b0;
   int                   hold_left = 0;
   int                   numbers_taken = 0;
   int                   chars_taken = 0;
   int                   error_count = 0;
   int                   quiet_cycles = 0;
   int                   radix_plan[12] = '{2, 36, 0, 63, 16, 1, 37, 8, 3, 10, 10, 10};
   logic signed [VW-1:0] directed_values[20] = '{
      0, 1, -1, 9, 10, -10, 99, 100, 42, -5,
      32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001, 1234567890, -987654321,
      32'sh55555555, 32'shAAAAAAAA, 1000000000, 7, -1000000000};

   int_to_radix_ascii_unit #(
      .VALUE_WIDTH(VW)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_character   (rsp_character),
      .rsp_last        (rsp_last),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic digit_type clamp_base(input digit_type raw);
      digit_type base;
      base = raw;
      if (raw < RADIX_MIN) begin
         base = RADIX_MIN;
      end else if (raw > RADIX_MAX) begin
         base = RADIX_MAX;
      end
      return base;
   endfunction

   // expand one number into its characters, most significant first
   function automatic void spell_number(input logic signed [VW-1:0] value,
                                        input digit_type raw_radix);
      logic [VW-1:0] magnitude;
      logic [VW-1:0] base;
      digit_type     digits[$];
      text_char_t    item;
      magnitude = value[VW-1] ? -value : value;
      base = clamp_base(raw_radix);
      do begin
         digits.push_front(digit_type'(magnitude % base));
         magnitude = magnitude / base;
      end while (magnitude != 0);
      if (value[VW-1]) begin
         item.character = ASCII_MINUS;
         item.last = 1'b0;
         expected_chars.push_back(item);
      end
      foreach (digits[k]) begin
         if (digits[k] < DECIMAL_DIGITS) begin
            item.character = ASCII_ZERO + char_type'(digits[k]);
         end else begin
            item.character = ASCII_LETTER_A + char_type'(digits[k] - DECIMAL_DIGITS);
         end
         item.last = (k == digits.size() - 1);
         expected_chars.push_back(item);
      end
   endfunction

   function automatic logic signed [VW-1:0] pick_value(input digit_type base);
      logic signed [VW-1:0] v;
      int                   sel;
      sel = $urandom_range(9);
      case (sel)
         0: begin
            case ($urandom_range(4))
               0: v = 0;
               1: v = 1;
               2: v = -1;
               3: v = {1'b0, {(VW-1){1'b1}}};
               default: v = {1'b1, {(VW-1){1'b0}}};
            endcase
         end
         1, 2: v = $urandom_range(1000);
         3: begin
            v = 1;
            v = (v << $urandom_range(VW-1)) - $urandom_range(1);
         end
         4: v = base - 1 + $urandom_range(2);
         default: v = $urandom;
      endcase
      if (sel >= 1 && sel <= 4 && $urandom_range(1) == 1) begin
         v = -v;
      end
      return v;
   endfunction

   task automatic wait_idle();
      while (pending_values.size() != 0 || req_valid || expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   // driver: hold the item until it is taken, then advance
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_values.size() != 0 && (steady_phase || $urandom_range(99) >= 7)) begin
            req_valid <= 1'b1;
            req_value <= pending_values.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off to back the block up
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && numbers_taken == 60) begin
         rsp_stall <= 1'b1;
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_stall <= !steady_phase && $urandom_range(99) < 7;
      end
   end

   always @(posedge clock) begin : check_rsp
      text_char_t want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            spell_number(req_value, radix_setting);
            numbers_taken <= numbers_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            chars_taken <= chars_taken + 1;
            if (expected_chars.size() == 0) begin
               error_count++;
               $display("%0t: unexpected character %h last %b", $time, rsp_character, rsp_last);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_character !== want.character) begin
                  error_count++;
                  $display("%0t: character expected %h actual %h", $time,
                           want.character, rsp_character);
               end
               if (rsp_last !== want.last) begin
                  error_count++;
                  $display("%0t: last expected %b actual %b", $time, want.last, rsp_last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset radix, decimal extremes first
      foreach (directed_values[i]) begin
         pending_values.push_back(directed_values[i]);
      end
      for (int i = 0; i < PHASE_ITEMS / 2; i++) begin
         pending_values.push_back(pick_value(clamp_base(radix_setting)));
      end

      radix_plan[10] = $urandom_range(RADIX_MIN, RADIX_MAX);
      radix_plan[11] = $urandom_range(63);
      foreach (radix_plan[p]) begin
         wait_idle();
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data <= digit_type'(radix_plan[p]);
         radix_setting = digit_type'(radix_plan[p]);
         @(negedge clock);
         csr_write_enable <= 1'b0;
         steady_phase = (p == 4 || p == 5);
         // the most negative value gives the longest text in every base
         pending_values.push_back({1'b1, {(VW-1){1'b0}}});
         for (int i = 1; i < PHASE_ITEMS; i++) begin
            pending_values.push_back(pick_value(clamp_base(radix_setting)));
         end
      end
      wait_idle();
      repeat (20) @(posedge clock);

      $display("Converted %0d numbers into %0d characters over %0d radix settings,",
               numbers_taken, chars_taken, $size(radix_plan) + 1);
      $display("including clamped bases, random stalls and one long output hold-off.");
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/i2ra_pkg.sv
rtl/core/i2ra_div_step.sv
rtl/core/int_to_radix_ascii_unit.sv
verif/testbench.sv
